### rtl/lfu_pkg.sv
// Shared constants and controller/datapath interface types for the LFU cache engine.
package lfu_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int CAP_W           = 5;
    localparam int KEY_W           = 32;
    localparam int DATA_W          = 32;
    localparam int USE_W           = 16;

    localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
    localparam logic [USE_W-1:0]  USE_MAX    = 16'hFFFF;
    localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic start;     // latch request, clear scan results, rewind counter
        logic rd_en;     // read entry at counter, advance counter
        logic pass_upd;  // reads belong to the update pass
        logic decide;    // latch decision, rewind counter
        logic load_out;  // move result into output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic pass_last; // counter has passed the last entry
        logic out_free;  // output register can take a result
    } status_t;

endpackage

### rtl/lfu_ctrl.sv
// Request sequencer of the LFU cache engine: scan pass, decision, update pass, response.
module lfu_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            req_valid,
    output logic            req_ready,
    input  lfu_pkg::status_t status,
    output lfu_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPDATE,
        ST_RESP
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        req_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.rd_en = !status.pass_last;
                if (status.pass_last) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                cmd.pass_upd = 1'b1;
                cmd.rd_en    = !status.pass_last;
                if (status.pass_last) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/lfu_dp.sv
// Datapath of the LFU cache engine: entry memories, valid bits, scan and update logic.
module lfu_dp #(
    parameter int MAX_ENTRIES = lfu_pkg::MAX_ENTRIES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [lfu_pkg::CAP_W-1:0]         cfg_wdata,
    input  logic                              s_action,
    input  logic signed [lfu_pkg::KEY_W-1:0]  s_lookup_key,
    input  logic signed [lfu_pkg::DATA_W-1:0] s_write_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_hit,
    output logic signed [lfu_pkg::DATA_W-1:0] m_read_value,
    output logic                              m_evicted,
    input  lfu_pkg::cmd_t                     cmd,
    output lfu_pkg::status_t                  status
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (OCC_W > lfu_pkg::CAP_W) ? OCC_W : lfu_pkg::CAP_W;
    localparam int KW    = lfu_pkg::KEY_W;
    localparam int DW    = lfu_pkg::DATA_W;
    localparam int UW    = lfu_pkg::USE_W;

    // entry storage
    logic [KW-1:0]    mem_key  [MAX_ENTRIES];
    logic [DW-1:0]    mem_val  [MAX_ENTRIES];
    logic [UW-1:0]    mem_use  [MAX_ENTRIES];
    logic [IDX_W-1:0] mem_rank [MAX_ENTRIES];

    logic [KW-1:0]    rd_key_reg;
    logic [DW-1:0]    rd_val_reg;
    logic [UW-1:0]    rd_use_reg;
    logic [IDX_W-1:0] rd_rank_reg;

    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [KW-1:0]    wr_key;
    logic [DW-1:0]    wr_val;
    logic [UW-1:0]    wr_use;
    logic [IDX_W-1:0] wr_rank;

    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [OCC_W-1:0]       occ_reg;
    logic [lfu_pkg::CAP_W-1:0] cap_reg;

    logic [IDX_W:0]   cnt_reg;
    logic             p_vld_reg;
    logic             p_upd_reg;
    logic [IDX_W-1:0] p_idx_reg;

    // request
    logic          act_reg;
    logic [KW-1:0] key_reg;
    logic [DW-1:0] wv_reg;

    // scan results
    logic             mf_reg, vf_reg, ff_reg;
    logic [IDX_W-1:0] m_idx_reg, v_idx_reg, f_idx_reg;
    logic [IDX_W-1:0] m_rank_reg, v_rank_reg;
    logic [UW-1:0]    v_use_reg;
    logic [DW-1:0]    m_val_reg;

    // decision
    logic             touch_reg, ins_reg, ev_reg;
    logic [IDX_W-1:0] slot_reg;
    logic             res_hit_reg;
    logic [DW-1:0]    res_val_reg;

    // output register
    logic          out_vld_reg;
    logic          out_hit_reg;
    logic [DW-1:0] out_val_reg;
    logic          out_ev_reg;

    logic p_entry_vld;
    logic cap_zero;
    logic full;
    logic dec_touch, dec_ins, dec_ev;
    logic [IDX_W-1:0] dec_slot;

    assign status.pass_last = (cnt_reg == (IDX_W+1)'(MAX_ENTRIES));
    assign status.out_free  = !out_vld_reg || m_ready;

    assign p_entry_vld = valid_reg[p_idx_reg];

    assign cap_zero = (cap_reg == '0);
    assign full     = (CMP_W'(occ_reg) >= CMP_W'(cap_reg)) ||
                      (occ_reg == OCC_W'(MAX_ENTRIES));
    assign dec_touch = !cap_zero && mf_reg;
    assign dec_ins   = !cap_zero && (act_reg == lfu_pkg::ACT_PUT) && !mf_reg;
    assign dec_ev    = dec_ins && full;
    always_comb begin
        if (dec_ev) begin
            dec_slot = (ff_reg && (f_idx_reg < v_idx_reg)) ? f_idx_reg : v_idx_reg;
        end else begin
            dec_slot = f_idx_reg;
        end
    end

    // update pass write-back
    always_comb begin
        wr_en   = 1'b0;
        wr_idx  = p_idx_reg;
        wr_key  = rd_key_reg;
        wr_val  = rd_val_reg;
        wr_use  = rd_use_reg;
        wr_rank = rd_rank_reg;
        if (p_vld_reg && p_upd_reg) begin
            if (touch_reg && p_entry_vld) begin
                wr_en = 1'b1;
                if (p_idx_reg == m_idx_reg) begin
                    wr_rank = '0;
                    wr_use  = (rd_use_reg == lfu_pkg::USE_MAX) ? rd_use_reg
                                                               : rd_use_reg + 1'b1;
                    if (act_reg == lfu_pkg::ACT_PUT) begin
                        wr_val = wv_reg;
                    end
                end else if (rd_rank_reg < m_rank_reg) begin
                    wr_rank = rd_rank_reg + 1'b1;
                end
            end else if (ins_reg) begin
                if (p_idx_reg == slot_reg) begin
                    wr_en   = 1'b1;
                    wr_key  = key_reg;
                    wr_val  = wv_reg;
                    wr_use  = UW'(1);
                    wr_rank = '0;
                end else if (p_entry_vld && !(ev_reg && (rd_rank_reg > v_rank_reg))) begin
                    // evicted entry is already invalid; newer ones age by one to close its gap
                    wr_en   = 1'b1;
                    wr_rank = rd_rank_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_key[wr_idx]  <= wr_key;
            mem_val[wr_idx]  <= wr_val;
            mem_use[wr_idx]  <= wr_use;
            mem_rank[wr_idx] <= wr_rank;
        end
        if (cmd.rd_en) begin
            rd_key_reg  <= mem_key[cnt_reg[IDX_W-1:0]];
            rd_val_reg  <= mem_val[cnt_reg[IDX_W-1:0]];
            rd_use_reg  <= mem_use[cnt_reg[IDX_W-1:0]];
            rd_rank_reg <= mem_rank[cnt_reg[IDX_W-1:0]];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= lfu_pkg::CAP_RESET;
            valid_reg   <= '0;
            occ_reg     <= '0;
            cnt_reg     <= '0;
            p_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
            if (cmd.start || cmd.decide) begin
                cnt_reg <= '0;
            end else if (cmd.rd_en) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            p_vld_reg <= cmd.rd_en;
            if (cmd.decide) begin
                if (dec_ev) begin
                    valid_reg[v_idx_reg] <= 1'b0;
                end
                if (dec_ins && !dec_ev) begin
                    occ_reg <= occ_reg + 1'b1;
                end
            end
            if (p_vld_reg && p_upd_reg && ins_reg && (p_idx_reg == slot_reg)) begin
                valid_reg[slot_reg] <= 1'b1;
            end
            if (cmd.load_out) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        p_idx_reg <= cnt_reg[IDX_W-1:0];
        p_upd_reg <= cmd.pass_upd;
        if (cmd.start) begin
            act_reg <= s_action;
            key_reg <= s_lookup_key;
            wv_reg  <= s_write_value;
            mf_reg  <= 1'b0;
            vf_reg  <= 1'b0;
            ff_reg  <= 1'b0;
        end
        if (p_vld_reg && !p_upd_reg) begin
            if (p_entry_vld && !mf_reg && (rd_key_reg == key_reg)) begin
                mf_reg     <= 1'b1;
                m_idx_reg  <= p_idx_reg;
                m_rank_reg <= rd_rank_reg;
                m_val_reg  <= rd_val_reg;
            end
            if (p_entry_vld && (!vf_reg || (rd_use_reg < v_use_reg) ||
                ((rd_use_reg == v_use_reg) && (rd_rank_reg > v_rank_reg)))) begin
                vf_reg     <= 1'b1;
                v_idx_reg  <= p_idx_reg;
                v_use_reg  <= rd_use_reg;
                v_rank_reg <= rd_rank_reg;
            end
            if (!p_entry_vld && !ff_reg) begin
                ff_reg    <= 1'b1;
                f_idx_reg <= p_idx_reg;
            end
        end
        if (cmd.decide) begin
            touch_reg   <= dec_touch;
            ins_reg     <= dec_ins;
            ev_reg      <= dec_ev;
            slot_reg    <= dec_slot;
            res_hit_reg <= dec_touch;
            res_val_reg <= (dec_touch && (act_reg == lfu_pkg::ACT_GET)) ? m_val_reg
                                                                       : lfu_pkg::MISS_VALUE;
        end
        if (cmd.load_out) begin
            out_hit_reg <= res_hit_reg;
            out_val_reg <= res_val_reg;
            out_ev_reg  <= ev_reg;
        end
    end

    assign m_valid      = out_vld_reg;
    assign m_hit        = out_hit_reg;
    assign m_read_value = out_val_reg;
    assign m_evicted    = out_ev_reg;

endmodule

### rtl/lfu_cache_engine.sv
// Top level of the LFU cache engine: sequencer plus entry datapath.
//
// Key-value cache of up to MAX_ENTRIES entries with least-frequently-used
// replacement, ties broken toward the least recently used entry. Each transfer
// on the s_ channel is a get (s_action 0) or a put (s_action 1) and yields
// exactly one transfer on the m_ channel. A request takes two passes: one
// pass over the entry memory finds the key, the victim and a free slot, a
// second read-modify-write pass ages the ranks and writes the touched or new
// entry; the single read port of the entry memory reads one entry per cycle
// in each pass. One request is in work at a time; a new request is taken
// while the previous result still waits in the output register. cfg_wdata
// sets the usable capacity (reset 16, clamped to MAX_ENTRIES, zero turns
// every request into a miss that changes nothing); write it only while the
// engine is idle. No clearing pass is needed after reset.
module lfu_cache_engine #(
    parameter int MAX_ENTRIES = lfu_pkg::MAX_ENTRIES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // capacity register
    input  logic                              cfg_we,
    input  logic [lfu_pkg::CAP_W-1:0]         cfg_wdata,
    // request channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_action,
    input  logic signed [lfu_pkg::KEY_W-1:0]  s_lookup_key,
    input  logic signed [lfu_pkg::DATA_W-1:0] s_write_value,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_hit,
    output logic signed [lfu_pkg::DATA_W-1:0] m_read_value,
    output logic                              m_evicted
);

    lfu_pkg::cmd_t    cmd;
    lfu_pkg::status_t status;

    // sequencer: idle -> scan -> decide -> update -> respond
    lfu_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_valid),
        .req_ready (s_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // entry memories, valid bits, occupancy and output register
    lfu_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_action      (s_action),
        .s_lookup_key  (s_lookup_key),
        .s_write_value (s_write_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit         (m_hit),
        .m_read_value  (m_read_value),
        .m_evicted     (m_evicted),
        .cmd           (cmd),
        .status        (status)
    );

endmodule

### test/lfu_cache_engine_tb.sv
// Self-checking testbench for the LFU cache engine: directed and random gets and puts.
`timescale 1ns / 1ps

module lfu_cache_engine_tb;

    localparam int N_ENTRIES = lfu_pkg::MAX_ENTRIES_DEF;
    localparam int PERIOD    = 4;
    localparam int DRAIN_CYC = 2 * N_ENTRIES + 20;
    localparam int KW        = lfu_pkg::KEY_W;
    localparam int DW        = lfu_pkg::DATA_W;
    localparam int UW        = lfu_pkg::USE_W;
    localparam int CW        = lfu_pkg::CAP_W;

    typedef struct packed {
        logic          hit;
        logic [DW-1:0] rd;
        logic          ev;
    } lookup_res_t;

    logic              aclk;
    logic              aresetn;
    logic              cfg_we;
    logic [CW-1:0]     cfg_wdata;
    logic              s_valid;
    logic              s_ready;
    logic              s_action;
    logic signed [KW-1:0] s_lookup_key;
    logic signed [DW-1:0] s_write_value;
    logic              m_valid;
    logic              m_ready;
    logic              m_hit;
    logic signed [DW-1:0] m_read_value;
    logic              m_evicted;

    lfu_cache_engine DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_lookup_key  (s_lookup_key),
        .s_write_value (s_write_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit         (m_hit),
        .m_read_value  (m_read_value),
        .m_evicted     (m_evicted)
    );

    // Shadow copy of the cache contents.
    logic [CW-1:0]     shadow_cap;
    logic              sh_valid [N_ENTRIES];
    logic [KW-1:0]     sh_key   [N_ENTRIES];
    logic [DW-1:0]     sh_val   [N_ENTRIES];
    logic [UW-1:0]     sh_uses  [N_ENTRIES];
    int unsigned       sh_rank  [N_ENTRIES];
    int unsigned       sh_occ;

    lookup_res_t pending_results[$];
    int          err_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_cycles;   // receiver hold-off, counted down in its own process
    logic [KW-1:0] key_pool[8];

    initial begin
        aclk = 1'b0;
        forever #(PERIOD / 2) aclk = ~aclk;
    end

    // Generous fixed limit on the whole run.
    initial begin
        #(PERIOD * 1000000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int find_slot(logic [KW-1:0] k);
        for (int i = 0; i < N_ENTRIES; i++)
            if (sh_valid[i] && sh_key[i] == k) return i;
        return -1;
    endfunction

    // Move entry idx to rank 0; newer entries age by one.
    function automatic void make_recent(int idx);
        int unsigned r;
        r = sh_rank[idx];
        for (int j = 0; j < N_ENTRIES; j++)
            if (sh_valid[j] && sh_rank[j] < r) sh_rank[j]++;
        sh_rank[idx] = 0;
    endfunction

    function automatic void bump_uses(int idx);
        if (sh_uses[idx] != lfu_pkg::USE_MAX) sh_uses[idx]++;
    endfunction

    function automatic lookup_res_t predict_lookup(logic act, logic [KW-1:0] k,
                                                   logic [DW-1:0] v);
        lookup_res_t res;
        int unsigned cap;
        int idx, vic, fr;
        int unsigned r;
        res = '{hit: 1'b0, rd: lfu_pkg::MISS_VALUE, ev: 1'b0};
        cap = (shadow_cap > N_ENTRIES) ? N_ENTRIES : shadow_cap;
        if (cap == 0) return res;
        idx = find_slot(k);
        if (idx >= 0) begin
            res.hit = 1'b1;
            if (act == lfu_pkg::ACT_GET) res.rd = sh_val[idx];
            else sh_val[idx] = v;
            bump_uses(idx);
            make_recent(idx);
        end else if (act == lfu_pkg::ACT_PUT) begin
            if (sh_occ >= cap) begin
                vic = -1;
                for (int i = 0; i < N_ENTRIES; i++) begin
                    if (!sh_valid[i]) continue;
                    if (vic < 0 || sh_uses[i] < sh_uses[vic] ||
                        (sh_uses[i] == sh_uses[vic] && sh_rank[i] > sh_rank[vic]))
                        vic = i;
                end
                if (vic >= 0) begin
                    r = sh_rank[vic];
                    sh_valid[vic] = 1'b0;
                    for (int j = 0; j < N_ENTRIES; j++)
                        if (sh_valid[j] && sh_rank[j] > r) sh_rank[j]--;
                    if (sh_occ > 0) sh_occ--;
                    res.ev = 1'b1;
                end
            end
            fr = -1;
            for (int j = N_ENTRIES - 1; j >= 0; j--)
                if (!sh_valid[j]) fr = j;
            if (fr >= 0) begin
                for (int t = 0; t < N_ENTRIES; t++)
                    if (sh_valid[t]) sh_rank[t]++;
                sh_valid[fr] = 1'b1;
                sh_key[fr]   = k;
                sh_val[fr]   = v;
                sh_uses[fr]  = UW'(1);
                sh_rank[fr]  = 0;
                sh_occ++;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [DW-1:0] got,
                                   logic [DW-1:0] want);
        $display("%0t: %s got %h want %h", $realtime, what, got, want);
        err_count++;
    endtask

    // Send one request; waits for the transfer. Valid drops only while idling.
    task automatic send_request(logic act, logic [KW-1:0] k, logic [DW-1:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_action      <= act;
        s_lookup_key  <= k;
        s_write_value <= v;
        pending_results.push_back(predict_lookup(act, k, v));
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        while (pending_results.size() != 0 && guard < 100000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (DRAIN_CYC) @(posedge aclk);
    endtask

    task automatic set_capacity(logic [CW-1:0] c);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= c;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        shadow_cap = c;
    endtask

    // Receiver: random stalls plus an optional long hold-off.
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready     <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result checker: each transfer against the oldest expectation.
    always @(posedge aclk) begin
        lookup_res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", m_read_value, '0);
            end else begin
                want = pending_results.pop_front();
                if (m_hit !== want.hit)
                    report_mismatch("hit", DW'(m_hit), DW'(want.hit));
                if (m_read_value !== want.rd)
                    report_mismatch("read_value", m_read_value, want.rd);
                if (m_evicted !== want.ev)
                    report_mismatch("evicted", DW'(m_evicted), DW'(want.ev));
            end
        end
    end

    task automatic test_directed();
        set_capacity(5'd2);
        send_request(lfu_pkg::ACT_GET, 32'h0000_0000, 32'h1234_5678);  // empty miss
        send_request(lfu_pkg::ACT_PUT, 32'h8000_0000, 32'hFFFF_FFFF);
        send_request(lfu_pkg::ACT_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(lfu_pkg::ACT_GET, 32'h8000_0000, 32'h0);           // hit, count 2
        send_request(lfu_pkg::ACT_PUT, 32'h7FFF_FFFF, 32'h7FFF_FFFF);   // update, count 2
        send_request(lfu_pkg::ACT_PUT, 32'h0000_0001, 32'h0);           // tie: LRU goes
        send_request(lfu_pkg::ACT_GET, 32'h8000_0000, 32'h0);
        send_request(lfu_pkg::ACT_PUT, 32'hFFFF_FFFF, 32'h5555_5555);   // lowest count goes
        set_capacity(5'd0);                                              // zero capacity
        send_request(lfu_pkg::ACT_PUT, 32'h0000_0042, 32'h1);
        send_request(lfu_pkg::ACT_GET, 32'hFFFF_FFFF, 32'h0);
        set_capacity(5'd31);                                             // clamp to max
        send_request(lfu_pkg::ACT_GET, 32'hFFFF_FFFF, 32'h0);            // kept entries return
        for (int i = 0; i < 6; i++)
            send_request(lfu_pkg::ACT_PUT, KW'(i + 100), DW'(i));
        set_capacity(5'd1);                                              // lowered below occupancy
        send_request(lfu_pkg::ACT_PUT, 32'h0000_0200, 32'hAAAA_AAAA);
        send_request(lfu_pkg::ACT_GET, 32'h0000_0200, 32'h0);
    endtask

    // Long receiver hold-off while requests keep coming.
    task automatic test_backpressure();
        set_capacity(5'd16);
        hold_cycles = 400;
        for (int i = 0; i < 6; i++) send_request(lfu_pkg::ACT_GET, 32'h0000_0200, 32'h0);
    endtask

    // One hot key hit over and over, then updated.
    task automatic test_hot_key();
        send_request(lfu_pkg::ACT_PUT, 32'h0BAD_CAFE, 32'h1);
        for (int i = 0; i < 30; i++) send_request(lfu_pkg::ACT_GET, 32'h0BAD_CAFE, 32'h0);
        send_request(lfu_pkg::ACT_PUT, 32'h0BAD_CAFE, 32'h2);
    endtask

    task automatic test_random(int n, int cap_lo, int cap_hi);
        logic act;
        logic [KW-1:0] k;
        set_capacity(5'($urandom_range(cap_hi, cap_lo)));
        for (int i = 0; i < n; i++) begin
            act = 1'($urandom_range(1));
            if ($urandom_range(9) < 8) k = key_pool[$urandom_range(7)];
            else k = $urandom;
            send_request(act, k, $urandom);
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_action      = lfu_pkg::ACT_GET;
        s_lookup_key  = '0;
        s_write_value = '0;
        m_ready       = 1'b0;
        hold_cycles   = 0;
        err_count     = 0;
        send_idle_pct = 12;
        recv_idle_pct = 53;
        shadow_cap    = lfu_pkg::CAP_RESET;
        sh_occ        = 0;
        for (int i = 0; i < N_ENTRIES; i++) begin
            sh_valid[i] = 1'b0;
            sh_key[i]   = '0;
            sh_val[i]   = '0;
            sh_uses[i]  = '0;
            sh_rank[i]  = 0;
        end
        for (int i = 0; i < 8; i++) key_pool[i] = $urandom;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_backpressure();
        test_random(120, 1, 6);
        send_idle_pct = 53;
        recv_idle_pct = 12;
        test_random(120, 8, 16);
        test_random(40, 0, 0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(120, 3, 31);
        test_random(60, 16, 16);
        test_hot_key();
        wait_idle();

        if (pending_results.size() == 0 && err_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
